// ===== rtl/l3bh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package l3bh_pkg;

    // Seed offset subtracted from the message length
    localparam logic [31:0] SEED_MAGIC = 32'h2145_E233;

    // Default depth of the block queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Operation codes carried in a queue entry
    localparam logic [1:0] OP_EMPTY   = 2'd0;  // zero-length message, hash 0
    localparam logic [1:0] OP_MIX     = 2'd1;  // add block, run mix rounds
    localparam logic [1:0] OP_FINAL   = 2'd2;  // add last block, finalize
    localparam logic [1:0] OP_MIX_FIN = 2'd3;  // mix full block, then finalize one byte

    // One queue entry: work for the back end
    typedef struct packed {
        logic [1:0]  op;
        logic        first;       // start from seed instead of running state
        logic [31:0] seed;
        logic [95:0] words;       // block, three little-endian words
        logic [7:0]  tail_byte;   // lone byte of the final block for OP_MIX_FIN
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/l3bh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module l3bh_front
    import l3bh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_message_length,
    input  wire logic        i_last,
    input  wire logic        i_empty_message,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam logic [3:0] FILL_FULL = 4'd12;

    logic        r_in_msg;
    logic        r_first;
    logic [31:0] r_seed;
    logic [95:0] r_words;
    logic [3:0]  r_fill;

    logic        acc;
    logic        eff_first;
    logic [31:0] eff_seed;
    logic [3:0]  eff_fill;
    logic [95:0] eff_words;
    logic [95:0] byte_word;
    logic [95:0] placed;
    logic        full_blk;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    // Current message context; a first word starts from the seed
    assign eff_first = r_in_msg ? r_first : 1'b1;
    assign eff_seed  = r_in_msg ? r_seed : (i_message_length - SEED_MAGIC);
    assign eff_fill  = r_in_msg ? r_fill : 4'd0;
    assign eff_words = r_in_msg ? r_words : 96'd0;
    assign full_blk  = (eff_fill == FILL_FULL);

    // Little-endian byte placement into the pending block
    assign byte_word = {88'd0, i_data_byte};
    assign placed    = eff_words | (byte_word << {eff_fill, 3'b000});

    // Classify the word and build the queue entry
    always_comb begin
        o_push            = 1'b0;
        o_entry.op        = OP_EMPTY;
        o_entry.first     = eff_first;
        o_entry.seed      = eff_seed;
        o_entry.words     = eff_words;
        o_entry.tail_byte = i_data_byte;
        if (i_empty_message) begin
            o_push     = acc;
            o_entry.op = OP_EMPTY;
        end else if (full_blk && i_last) begin
            o_push     = acc;
            o_entry.op = OP_MIX_FIN;
        end else if (full_blk) begin
            o_push     = acc;
            o_entry.op = OP_MIX;
        end else if (i_last) begin
            o_push        = acc;
            o_entry.op    = OP_FINAL;
            o_entry.words = placed;
        end
    end

    // Message tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_first  <= 1'b0;
            r_fill   <= 4'd0;
        end else if (acc) begin
            if (i_empty_message || i_last) begin
                r_in_msg <= 1'b0;
                r_fill   <= 4'd0;
            end else begin
                r_in_msg <= 1'b1;
                r_first  <= full_blk ? 1'b0 : eff_first;
                r_fill   <= full_blk ? 4'd1 : (eff_fill + 4'd1);
            end
        end
    end

    // Block payload
    always_ff @(posedge i_clk) begin
        if (acc && !i_empty_message && !i_last) begin
            r_seed  <= eff_seed;
            r_words <= full_blk ? byte_word : placed;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/l3bh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module l3bh_queue
    import l3bh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : (r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : (r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/l3bh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module l3bh_back
    import l3bh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_entry      i_q_entry,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);

    localparam logic [2:0] ROUNDS = 3'd6;
    localparam int         NSTG   = 8;   // load stage plus seven final steps

    typedef struct packed {
        logic        zero;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] s4;
        logic [31:0] s5;
        logic [31:0] s6;
        logic [31:0] h;
    } t_fin;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
        rotl = (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int k);
        rotr = (x >> k) | (x << (32 - k));
    endfunction

    // One finalization step per pipeline stage
    function automatic t_fin fin_step(input t_fin x, input logic [2:0] idx);
        t_fin y;
        y = x;
        case (idx)
            3'd0: y.s1 = (x.b ^ x.c) - rotl(x.b, 14);
            3'd1: y.s2 = (x.a ^ x.s1) - rotl(x.s1, 11);
            3'd2: y.s3 = (x.s2 ^ x.b) - rotr(x.s2, 7);
            3'd3: y.s4 = (x.s3 ^ x.s1) - rotl(x.s3, 16);
            3'd4: y.s5 = (x.s2 ^ x.s4) - rotl(x.s4, 4);
            3'd5: y.s6 = (x.s5 ^ x.s3) - rotl(x.s5, 14);
            3'd6: y.h  = (x.s6 ^ x.s4) - rotr(x.s6, 8);
            default: y = x;
        endcase
        fin_step = y;
    endfunction

    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [2:0]  r_rnd;        // 0 idle, else mix round r_rnd-1 runs
    logic        r_fin_pend;
    logic [7:0]  r_fin_byte;
    logic        r_vld [NSTG];
    t_fin        r_st  [NSTG];
    logic        r_o_valid;
    logic [31:0] r_hash;

    logic        fin_en;
    logic        load_mix;
    logic        fin_push;
    t_fin        fin_in;
    logic [31:0] sum_a;
    logic [31:0] sum_b;
    logic [31:0] sum_c;
    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    logic [31:0] rnd_c;
    logic [2:0]  rnd_idx;

    assign o_valid      = r_o_valid;
    assign o_hash_value = r_hash;
    assign fin_en       = !r_o_valid || i_ready;

    // Block added to the seed or to the running state
    assign sum_a = (i_q_entry.first ? i_q_entry.seed : r_a) + i_q_entry.words[31:0];
    assign sum_b = (i_q_entry.first ? i_q_entry.seed : r_b) + i_q_entry.words[63:32];
    assign sum_c = (i_q_entry.first ? i_q_entry.seed : r_c) + i_q_entry.words[95:64];

    // One mix line per cycle
    assign rnd_idx = r_rnd - 3'd1;
    always_comb begin
        rnd_a = r_a;
        rnd_b = r_b;
        rnd_c = r_c;
        case (rnd_idx)
            3'd0: begin
                rnd_a = (r_a - r_c) ^ rotl(r_c, 4);
                rnd_c = r_c + r_b;
            end
            3'd1: begin
                rnd_b = (r_b - r_a) ^ rotl(r_a, 6);
                rnd_a = r_a + r_c;
            end
            3'd2: begin
                rnd_c = (r_c - r_b) ^ rotl(r_b, 8);
                rnd_b = r_b + r_a;
            end
            3'd3: begin
                rnd_a = (r_a - r_c) ^ rotl(r_c, 16);
                rnd_c = r_c + r_b;
            end
            3'd4: begin
                rnd_b = (r_b - r_a) ^ rotl(r_a, 19);
                rnd_a = r_a + r_c;
            end
            3'd5: begin
                rnd_c = (r_c - r_b) ^ rotl(r_b, 4);
                rnd_b = r_b + r_a;
            end
            default: begin
                rnd_a = r_a;
            end
        endcase
    end

    // Dispatch: send a pending final block, else take queue entries; none while a mix runs
    always_comb begin
        o_q_pop  = 1'b0;
        load_mix = 1'b0;
        fin_push = 1'b0;
        fin_in   = '0;
        if (r_rnd != 3'd0) begin
            fin_push = 1'b0;
        end else if (r_fin_pend) begin
            fin_push = fin_en;
            fin_in.a = r_a + {24'd0, r_fin_byte};
            fin_in.b = r_b;
            fin_in.c = r_c;
        end else if (i_q_valid) begin
            case (i_q_entry.op)
                OP_EMPTY: begin
                    o_q_pop     = fin_en;
                    fin_push    = fin_en;
                    fin_in.zero = 1'b1;
                end
                OP_FINAL: begin
                    o_q_pop  = fin_en;
                    fin_push = fin_en;
                    fin_in.a = sum_a;
                    fin_in.b = sum_b;
                    fin_in.c = sum_c;
                end
                OP_MIX, OP_MIX_FIN: begin
                    o_q_pop  = 1'b1;
                    load_mix = 1'b1;
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
    end

    // Mixing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd      <= 3'd0;
            r_fin_pend <= 1'b0;
        end else if (load_mix) begin
            r_rnd      <= 3'd1;
            r_fin_pend <= (i_q_entry.op == OP_MIX_FIN);
        end else if (r_rnd != 3'd0) begin
            r_rnd <= (r_rnd == ROUNDS) ? 3'd0 : (r_rnd + 3'd1);
        end else if (fin_push) begin
            r_fin_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_mix) begin
            r_a        <= sum_a;
            r_b        <= sum_b;
            r_c        <= sum_c;
            r_fin_byte <= i_q_entry.tail_byte;
        end else if (r_rnd != 3'd0) begin
            r_a <= rnd_a;
            r_b <= rnd_b;
            r_c <= rnd_c;
        end
    end

    // Finalization pipeline and output register, stalled together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (fin_en) begin
            r_vld[0] <= fin_push;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_o_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_en) begin
            r_st[0] <= fin_in;
            for (int k = 1; k < NSTG; k++) begin
                r_st[k] <= fin_step(r_st[k-1], 3'(k - 1));
            end
            r_hash <= r_st[NSTG-1].zero ? 32'd0 : r_st[NSTG-1].h;
        end
    end

`ifndef SYNTHESIS
    a_no_final_while_mixing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rnd != 3'd0) |-> (!fin_push && !o_q_pop))
        else $error("back end dispatched while mixing");
    a_pending_blocks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_pend |-> !o_q_pop)
        else $error("queue popped with a final block pending");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= ROUNDS)
        else $error("mix round counter out of range");
    a_mix_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_mix |=> (r_rnd == 3'd1))
        else $error("mix did not start after load");
`endif

endmodule

`default_nettype wire

// ===== rtl/lookup3_variant_byte_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    i_data_byte, i_message_length, i_last,
//                                          i_empty_message
// output   out        o_valid / i_ready    o_hash_value
//
// One byte word is taken per cycle while the block queue has room.
// A full 12-byte block holds the back end for a load and six mix rounds,
// overlapped with the bytes of the next block.
// With nothing ahead, a last byte passes the queue, the load stage, the final
// steps and the output register, after any mix; one hash per cycle if unstalled.
// Reset is synchronous, active low, and clears all control state.
// A stalled output holds the finalization pipeline; the front stalls only
// when the block queue is full.

module lookup3_variant_byte_hash
    import l3bh_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_message_length,
    input  wire logic        i_last,
    input  wire logic        i_empty_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);

    logic   q_full;
    logic   q_push;
    t_entry q_in;
    logic   q_pop;
    logic   q_valid;
    t_entry q_out;

    l3bh_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_last           (i_last),
        .i_empty_message  (i_empty_message),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_entry          (q_in)
    );

    l3bh_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    l3bh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire
